FILE: hdl/token_mutex_table_with_wait_queues_core_assert.svh
// Assertion macros for the lock table core
`ifndef TOKEN_MUTEX_TABLE_WITH_WAIT_QUEUES_CORE_ASSERT_SVH
`define TOKEN_MUTEX_TABLE_WITH_WAIT_QUEUES_CORE_ASSERT_SVH
// Implication checked every clock edge outside reset
`define TMT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked every clock edge outside reset
`define TMT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: hdl/tmtwq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmtwq_pkg
// Shared types and constants for the lock table core.
// ----------------------------------------------------------------------------
package tmtwq_pkg;
  localparam int unsigned NumLocksDef = 16;
  localparam int unsigned NumWaitSlotsDef = 16;

  typedef enum logic [2:0] {
    REQ_ACQUIRE = 3'd0,
    REQ_RELEASE = 3'd1,
    REQ_LOCK    = 3'd2,
    REQ_TRYLOCK = 3'd3,
    REQ_UNLOCK  = 3'd4
  } req_type_e;

  typedef enum logic [2:0] {
    ST_SUCCESS   = 3'd0,
    ST_INV_ID    = 3'd1,
    ST_INV_TOKEN = 3'd2,
    ST_NO_RES    = 3'd3,
    ST_LOCK_FAIL = 3'd4,
    ST_INV_OP    = 3'd5
  } status_e;
endpackage

FILE: hdl/tmtwq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmtwq_req_if / tmtwq_rsp_if
// Valid/ready channels for requests and replies.
// ----------------------------------------------------------------------------
interface tmtwq_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  requester;
  logic [7:0]  lock_id;
  logic [31:0] token_in;
  logic [31:0] fresh_token;
  modport source (output valid, req_type, requester, lock_id, token_in, fresh_token,
                  input ready);
  modport sink (input valid, req_type, requester, lock_id, token_in, fresh_token,
                output ready);
endinterface

interface tmtwq_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reply_to;
  logic [2:0]  status;
  logic [7:0]  granted_id;
  logic [31:0] granted_token;
  logic        last;
  modport source (output valid, reply_to, status, granted_id, granted_token, last,
                  input ready);
  modport sink (input valid, reply_to, status, granted_id, granted_token, last,
                output ready);
endinterface

FILE: hdl/tmtwq_entry_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmtwq_entry_mem
// Per-lock entry memory: token, allocated, locked, waiter head and tail.
// Valid bits stand in for the cleared reset value.
// ----------------------------------------------------------------------------
module tmtwq_entry_mem import tmtwq_pkg::*; #(
  parameter int unsigned NumLocks = NumLocksDef,
  parameter int unsigned NumWaitSlots = NumWaitSlotsDef,
  localparam int unsigned IdW = (NumLocks > 1) ? $clog2(NumLocks) : 1,
  localparam int unsigned SlotW = $clog2(NumWaitSlots + 1),
  localparam int unsigned EntW = 32 + 2 + 2 * SlotW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IdW-1:0]   rd_addr_i,
  output logic [EntW-1:0]  rd_data_o,
  input  logic             wr_en_i,
  input  logic [IdW-1:0]   wr_addr_i,
  input  logic [EntW-1:0]  wr_data_i
);
  logic [EntW-1:0] mem_q [NumLocks];
  logic [EntW-1:0] rdat_q;
  logic [NumLocks-1:0] vld_q;
  logic rvld_q;
  logic [SlotW-1:0] empty_mark;

  assign empty_mark = SlotW'(NumWaitSlots);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rdat_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[rd_addr_i];
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  // unwritten entries read as cleared: token 0, free, no waiters
  assign rd_data_o = rvld_q ? rdat_q : {32'd0, 2'b00, empty_mark, SlotW'(0)};
endmodule

FILE: hdl/tmtwq_slot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmtwq_slot_mem
// Wait slot memory: next link and requester per slot.
// Next links start as the chained free list; the requester field is
// written only when its enable is set, so relinking keeps it.
// ----------------------------------------------------------------------------
module tmtwq_slot_mem import tmtwq_pkg::*; #(
  parameter int unsigned NumWaitSlots = NumWaitSlotsDef,
  localparam int unsigned SlotW = $clog2(NumWaitSlots + 1),
  localparam int unsigned SIdxW = (NumWaitSlots > 1) ? $clog2(NumWaitSlots) : 1,
  localparam int unsigned SlW = SlotW + 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SIdxW-1:0] rd_addr_i,
  output logic [SlW-1:0]   rd_data_o,
  input  logic             wr_en_i,
  input  logic             wr_reqr_en_i,
  input  logic [SIdxW-1:0] wr_addr_i,
  input  logic [SlW-1:0]   wr_data_i
);
  logic [SlotW-1:0] nxt_q [NumWaitSlots];
  logic [7:0] who_q [NumWaitSlots];
  logic [SlW-1:0] rdat_q;
  logic [NumWaitSlots-1:0] vld_q;
  logic rvld_q;
  logic [SIdxW-1:0] raddr_q;
  logic [SlotW-1:0] init_next;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      nxt_q[wr_addr_i] <= wr_data_i[SlW-1 -: SlotW];
      if (wr_reqr_en_i) begin
        who_q[wr_addr_i] <= wr_data_i[7:0];
      end
    end
    rdat_q  <= {nxt_q[rd_addr_i], who_q[rd_addr_i]};
    raddr_q <= rd_addr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[rd_addr_i];
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign init_next = SlotW'(raddr_q) + SlotW'(1);
  assign rd_data_o = rvld_q ? rdat_q : {init_next, 8'd0};
endmodule

FILE: hdl/tmtwq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmtwq_ctrl
// Request sequencer: reads entries and slots, decides, writes back and
// emits reply beats, walking the waiter chain on release.
// ----------------------------------------------------------------------------
module tmtwq_ctrl import tmtwq_pkg::*; #(
  parameter int unsigned NumLocks = NumLocksDef,
  parameter int unsigned NumWaitSlots = NumWaitSlotsDef,
  localparam int unsigned IdW = (NumLocks > 1) ? $clog2(NumLocks) : 1,
  localparam int unsigned CntW = $clog2(NumLocks + 1),
  localparam int unsigned SlotW = $clog2(NumWaitSlots + 1),
  localparam int unsigned SIdxW = (NumWaitSlots > 1) ? $clog2(NumWaitSlots) : 1,
  localparam int unsigned EntW = 32 + 2 + 2 * SlotW,
  localparam int unsigned SlW = SlotW + 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tmtwq_req_if.sink        req,
  tmtwq_rsp_if.source      rsp,
  output logic [IdW-1:0]   ent_raddr_o,
  input  logic [EntW-1:0]  ent_rdata_i,
  output logic             ent_we_o,
  output logic [IdW-1:0]   ent_waddr_o,
  output logic [EntW-1:0]  ent_wdata_o,
  output logic [SIdxW-1:0] slot_raddr_o,
  input  logic [SlW-1:0]   slot_rdata_i,
  output logic             slot_we_o,
  output logic             slot_wreqr_o,
  output logic [SIdxW-1:0] slot_waddr_o,
  output logic [SlW-1:0]   slot_wdata_o,
  output logic             busy_o
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD    = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_SRD   = 7'b0001000,
    S_SEXEC = 7'b0010000,
    S_LINK  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e state_q;
  logic [2:0]  type_q;
  logic [7:0]  reqr_q, id_q;
  logic [31:0] tok_q, fresh_q;
  logic [IdW-1:0] fid_q [NumLocks];
  logic [IdW-1:0] fid_rd_q;
  logic [CntW-1:0] fid_cnt_q;
  logic [SlotW-1:0] fs_head_q;
  logic [SIdxW-1:0] fs_tail_q;
  logic [31:0] e_tok_q;
  logic        e_alloc_q, e_lock_q;
  logic [SlotW-1:0] e_head_q, e_tail_q;
  logic [SIdxW-1:0] cur_q;
  logic        link_req_q;
  logic [SIdxW-1:0] link_addr_q;
  logic [SIdxW-1:0] link_val_q;
  logic        o_valid_q, o_last_q;
  logic [7:0]  o_to_q, o_id_q;
  logic [2:0]  o_st_q;
  logic [31:0] o_tok_q;
  logic        done_q;
  logic [SlotW-1:0] empty_mark;
  logic [IdW-1:0] id_idx;
  logic [CntW:0] wr_sum;
  logic [IdW-1:0] wr_ptr;
  logic id_ok;
  logic o_free;

  assign empty_mark = SlotW'(NumWaitSlots);
  assign id_idx = id_q[IdW-1:0];
  assign id_ok = (9'(id_q) < 9'(NumLocks));
  assign o_free = !o_valid_q || rsp.ready;
  assign wr_sum = (CntW+1)'(fid_rd_q) + (CntW+1)'(fid_cnt_q);
  assign wr_ptr = (wr_sum >= (CntW+1)'(NumLocks)) ? IdW'(wr_sum - (CntW+1)'(NumLocks))
                                                  : IdW'(wr_sum);
  assign req.ready = (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  assign rsp.valid = o_valid_q;
  assign rsp.reply_to = o_to_q;
  assign rsp.status = o_st_q;
  assign rsp.granted_id = o_id_q;
  assign rsp.granted_token = o_tok_q;
  assign rsp.last = o_last_q;

  assign ent_raddr_o = id_idx;
  assign ent_waddr_o = (type_q == REQ_ACQUIRE) ? fid_q[fid_rd_q] : id_idx;
  assign slot_raddr_o = (state_q == S_EXEC) ? fs_head_q[SIdxW-1:0] : cur_q;

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      type_q  <= req.req_type;
      reqr_q  <= req.requester;
      id_q    <= req.lock_id;
      tok_q   <= req.token_in;
      fresh_q <= req.fresh_token;
    end
  end

  // main sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fid_rd_q   <= '0;
      fid_cnt_q  <= CntW'(NumLocks);
      fs_head_q  <= '0;
      fs_tail_q  <= SIdxW'(NumWaitSlots - 1);
      o_valid_q  <= 1'b0;
      link_req_q <= 1'b0;
      done_q     <= 1'b0;
      for (int i = 0; i < NumLocks; i++) fid_q[i] <= IdW'(i);
    end else begin
      if (rsp.ready) o_valid_q <= 1'b0;
      link_req_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (req.valid) state_q <= S_RD;
        S_RD: begin
          state_q <= S_EXEC;
          if (type_q == REQ_ACQUIRE) state_q <= S_OUT;
        end
        S_EXEC: begin
          {e_tok_q, e_alloc_q, e_lock_q, e_head_q, e_tail_q} <= ent_rdata_i;
          cur_q <= ent_rdata_i[SlotW +: SIdxW];
          state_q <= S_OUT;
          if (ent_rdata_i[EntW-1 -: 32] == tok_q && ent_rdata_i[EntW-33] &&
              id_ok && ent_rdata_i[2*SlotW-1 -: SlotW] != empty_mark &&
              ((type_q == REQ_UNLOCK && ent_rdata_i[EntW-34]) ||
               type_q == REQ_RELEASE))
            state_q <= S_SRD;
          else if (ent_rdata_i[EntW-1 -: 32] == tok_q && ent_rdata_i[EntW-33] &&
                   id_ok && type_q == REQ_LOCK &&
                   ent_rdata_i[EntW-34] && fs_head_q != empty_mark)
            state_q <= S_LINK;
        end
        S_SRD: state_q <= S_SEXEC;
        S_SEXEC: if (o_free) begin
          o_valid_q <= 1'b1;
          o_to_q    <= slot_rdata_i[7:0];
          o_st_q    <= (type_q == REQ_RELEASE) ? ST_INV_ID : ST_SUCCESS;
          o_id_q    <= id_q;
          o_tok_q   <= e_tok_q;
          o_last_q  <= 1'b0;
          // return slot to free pool
          link_req_q  <= (fs_head_q != empty_mark);
          link_addr_q <= fs_tail_q;
          link_val_q  <= cur_q;
          if (fs_head_q == empty_mark) fs_head_q <= SlotW'(cur_q);
          fs_tail_q <= cur_q;
          e_head_q  <= slot_rdata_i[SlW-1 -: SlotW];
          cur_q     <= slot_rdata_i[8 +: SIdxW];
          if (type_q == REQ_RELEASE && slot_rdata_i[SlW-1 -: SlotW] != empty_mark)
            state_q <= S_SRD;
          else
            state_q <= S_OUT;
        end
        S_LINK: begin
          // slot_rdata_i holds next of the popped free slot
          fs_head_q <= slot_rdata_i[SlW-1 -: SlotW];
          if (e_head_q == empty_mark) e_head_q <= fs_head_q;
          else begin
            link_req_q  <= 1'b1;
            link_addr_q <= e_tail_q[SIdxW-1:0];
            link_val_q  <= fs_head_q[SIdxW-1:0];
          end
          e_tail_q <= fs_head_q;
          state_q  <= S_OUT;
        end
        S_OUT: if (o_free) begin
          o_to_q   <= reqr_q;
          o_id_q   <= id_q;
          o_tok_q  <= 32'd0;
          o_last_q <= 1'b1;
          o_valid_q <= 1'b1;
          state_q  <= S_IDLE;
          if (type_q == REQ_ACQUIRE) begin
            if (fid_cnt_q == '0) begin
              o_st_q <= ST_NO_RES;
              o_id_q <= 8'd0;
            end else begin
              o_st_q  <= ST_SUCCESS;
              o_id_q  <= 8'(fid_q[fid_rd_q]);
              o_tok_q <= fresh_q;
              fid_rd_q <= (fid_rd_q == IdW'(NumLocks - 1)) ? '0 : fid_rd_q + IdW'(1);
              fid_cnt_q <= fid_cnt_q - CntW'(1);
            end
          end else if (!id_ok) o_st_q <= ST_INV_ID;
          else if (!e_alloc_q || e_tok_q != tok_q) o_st_q <= ST_INV_TOKEN;
          else begin
            case (type_q) inside
              REQ_RELEASE: begin
                o_st_q <= ST_SUCCESS;
                o_tok_q <= e_tok_q;
                if (fid_cnt_q < CntW'(NumLocks)) begin
                  fid_q[wr_ptr] <= id_idx;
                  fid_cnt_q <= fid_cnt_q + CntW'(1);
                end
              end
              REQ_LOCK, REQ_TRYLOCK: begin
                if (!e_lock_q) begin
                  o_st_q <= ST_SUCCESS;
                  o_tok_q <= e_tok_q;
                end else if (type_q == REQ_TRYLOCK) o_st_q <= ST_LOCK_FAIL;
                else if (done_q) o_valid_q <= o_valid_q && !rsp.ready;
                else o_st_q <= ST_NO_RES;
              end
              REQ_UNLOCK: begin
                if (!e_lock_q) o_st_q <= ST_LOCK_FAIL;
                else begin
                  o_st_q <= ST_SUCCESS;
                  o_tok_q <= e_tok_q;
                end
              end
              default: o_st_q <= ST_INV_OP;
            endcase
          end
        end
        default: state_q <= S_IDLE;
      endcase
      // mark a parked lock or a handoff; a handoff keeps the lock held
      if (state_q == S_LINK || state_q == S_SEXEC) done_q <= 1'b1;
      else if (state_q == S_IDLE) done_q <= 1'b0;
    end
  end

  // write-back of entry and slot
  always_comb begin
    ent_we_o = 1'b0;
    ent_wdata_o = {e_tok_q, e_alloc_q, e_lock_q, e_head_q, e_tail_q};
    slot_we_o = link_req_q;
    slot_wreqr_o = 1'b0;
    slot_waddr_o = link_addr_q;
    slot_wdata_o = {SlotW'(link_val_q), 8'd0};
    if (state_q == S_OUT && o_free) begin
      if (type_q == REQ_ACQUIRE) begin
        ent_we_o = (fid_cnt_q != '0);
        ent_wdata_o = {fresh_q, 1'b1, 1'b0, empty_mark, SlotW'(0)};
      end else if (id_ok && e_alloc_q && e_tok_q == tok_q) begin
        case (type_q) inside
          REQ_RELEASE: begin
            ent_we_o = 1'b1;
            ent_wdata_o = {32'd0, 2'b00, empty_mark, e_tail_q};
          end
          REQ_LOCK, REQ_TRYLOCK: begin
            ent_we_o = 1'b1;
            ent_wdata_o = {e_tok_q, 1'b1, 1'b1, e_head_q, e_tail_q};
          end
          REQ_UNLOCK: begin
            ent_we_o = 1'b1;
            ent_wdata_o = {e_tok_q, 1'b1, done_q, e_head_q, e_tail_q};
          end
          default: ent_we_o = 1'b0;
        endcase
      end
    end
    if (state_q == S_LINK) begin
      // park requester in the popped slot
      slot_we_o = 1'b1;
      slot_wreqr_o = 1'b1;
      slot_waddr_o = fs_head_q[SIdxW-1:0];
      slot_wdata_o = {empty_mark, reqr_q};
    end else if (state_q == S_SEXEC && o_free) begin
      slot_we_o = 1'b1;
      slot_wreqr_o = 1'b1;
      slot_waddr_o = cur_q;
      slot_wdata_o = {empty_mark, slot_rdata_i[7:0]};
    end
  end
endmodule

FILE: hdl/token_mutex_table_with_wait_queues_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_mutex_table_with_wait_queues_core
// Lock table with per-lock wait queues held in synchronous memories.
// ----------------------------------------------------------------------------
//  channel | dir | beat
//  req     | in  | req_type, requester, lock_id, token_in, fresh_token
//  rsp     | out | reply_to, status, granted_id, granted_token, last
//
// A request steps through accept, entry read, decide and reply; acquire skips
// the decide step. Parking a blocked lock adds the link state and each
// waiter walked (release flush, unlock handoff) adds a slot read and a slot
// step, paced by the registered reads of the entry and slot memories.
// Reset clears the sequencer and free lists at once; no clearing pass.
// A stalled reply holds the sequencer before its next reply beat.
module token_mutex_table_with_wait_queues_core import tmtwq_pkg::*; #(
  parameter int unsigned NumLocks = NumLocksDef,
  parameter int unsigned NumWaitSlots = NumWaitSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tmtwq_req_if.sink   req,
  tmtwq_rsp_if.source rsp
);
  localparam int unsigned IdW = (NumLocks > 1) ? $clog2(NumLocks) : 1;
  localparam int unsigned SlotW = $clog2(NumWaitSlots + 1);
  localparam int unsigned SIdxW = (NumWaitSlots > 1) ? $clog2(NumWaitSlots) : 1;
  localparam int unsigned EntW = 32 + 2 + 2 * SlotW;
  localparam int unsigned SlW = SlotW + 8;

  logic [IdW-1:0] ent_raddr, ent_waddr;
  logic [EntW-1:0] ent_rdata, ent_wdata;
  logic ent_we, slot_we, slot_wreqr, busy;
  logic [SIdxW-1:0] slot_raddr, slot_waddr;
  logic [SlW-1:0] slot_rdata, slot_wdata;

  tmtwq_entry_mem #(.NumLocks(NumLocks), .NumWaitSlots(NumWaitSlots)) u_ent (
    .clk_i, .rst_ni, .rd_addr_i(ent_raddr), .rd_data_o(ent_rdata),
    .wr_en_i(ent_we), .wr_addr_i(ent_waddr), .wr_data_i(ent_wdata)
  );

  tmtwq_slot_mem #(.NumWaitSlots(NumWaitSlots)) u_slot (
    .clk_i, .rst_ni, .rd_addr_i(slot_raddr), .rd_data_o(slot_rdata),
    .wr_en_i(slot_we), .wr_reqr_en_i(slot_wreqr), .wr_addr_i(slot_waddr),
    .wr_data_i(slot_wdata)
  );

  tmtwq_ctrl #(.NumLocks(NumLocks), .NumWaitSlots(NumWaitSlots)) u_ctrl (
    .clk_i, .rst_ni, .req, .rsp,
    .ent_raddr_o(ent_raddr), .ent_rdata_i(ent_rdata), .ent_we_o(ent_we),
    .ent_waddr_o(ent_waddr), .ent_wdata_o(ent_wdata),
    .slot_raddr_o(slot_raddr), .slot_rdata_i(slot_rdata), .slot_we_o(slot_we),
    .slot_wreqr_o(slot_wreqr), .slot_waddr_o(slot_waddr), .slot_wdata_o(slot_wdata),
    .busy_o(busy)
  );

`include "token_mutex_table_with_wait_queues_core_assert.svh"
  `TMT_ASSERT_IMP(a_no_accept_busy, busy, !req.ready)
  `TMT_ASSERT_NXT(a_accept_busy, req.valid && req.ready, busy)
  `TMT_ASSERT_IMP(a_status_range, rsp.valid, rsp.status <= ST_INV_OP)
endmodule
